// File: hdl/ledclk_pkg.sv
`timescale 1ns / 1ps
package ledclk_pkg;

  localparam int COUNT_W = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  // register index, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_BLINK_TICKS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLL_TICKS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_EVERY  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_SHOW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd4;

  localparam logic [COUNT_W-1:0] BLINK_TICKS_RST = 16'd500;
  localparam logic [COUNT_W-1:0] POLL_TICKS_RST  = 16'd300;
  localparam logic [COUNT_W-1:0] TEMP_EVERY_RST  = 16'd30000;
  localparam logic [COUNT_W-1:0] TEMP_SHOW_RST   = 16'd5000;
  localparam logic [3:0]         TEMP_OFFSET_RST = 4'd3;

  localparam logic [6:0] SEG_BLANK = 7'h00;
  localparam logic [6:0] SEG_STAR  = 7'h63;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [6:0] TEMP_MAX  = 7'd99;

  typedef struct packed {
    logic [COUNT_W-1:0] blink_ticks;
    logic [COUNT_W-1:0] poll_ticks;
    logic [COUNT_W-1:0] temp_every_ticks;
    logic [COUNT_W-1:0] temp_show_ticks;
    logic [3:0]         temp_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0] rank;
    logic       temp_mode;
    logic       blank_hi;
    logic       blank_lo;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] temp;
  } scan_req_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segments;
    logic       colon;
    logic       rtc_write;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
  } result_t;

  // {tens, ones} of a value below 128, tens taken modulo 10
  function automatic logic [7:0] dec_split(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] w;
    logic [6:0] rem;
    w = (v >= 7'd100) ? v - 7'd100 : v;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (w >= 7'(10 * k)) tens = 4'(k);
    end
    rem = w - 7'(tens) * 7'd10;
    return {tens, rem[3:0]};
  endfunction

  function automatic logic [6:0] digit_seg(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/ledclk_tick_if.sv
`timescale 1ns / 1ps
interface ledclk_tick_if;
  logic             valid;
  logic             ready;
  logic [4:0]       rtc_hour;
  logic [5:0]       rtc_minute;
  logic signed [7:0] rtc_temp;
  logic             main_hold;
  logic             main_click;
  logic             add_press;

  modport source (output valid, rtc_hour, rtc_minute, rtc_temp, main_hold, main_click,
                  add_press, input ready);
  modport sink   (input valid, rtc_hour, rtc_minute, rtc_temp, main_hold, main_click,
                  add_press, output ready);
endinterface

// File: hdl/ledclk_disp_if.sv
`timescale 1ns / 1ps
interface ledclk_disp_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_enable;
  logic [6:0] segments;
  logic       colon;
  logic       rtc_write;
  logic [4:0] set_hour;
  logic [5:0] set_minute;

  modport source (output valid, digit_enable, segments, colon, rtc_write, set_hour,
                  set_minute, input ready);
  modport sink   (input valid, digit_enable, segments, colon, rtc_write, set_hour,
                  set_minute, output ready);
endinterface

// File: hdl/led_clock_mode_and_display_scan_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake             Beat contents
// in_ch     in   valid/ready           rtc_hour, rtc_minute, rtc_temp, button events
// out_ch    out  valid/ready           digit_enable, segments, colon, RTC write strobe+time
// cfg (APB) in   psel/penable, pready  5 registers at 4*index, pready tied high
//
// One input beat per clock while in_ch.ready is high; each beat gives one registered output beat.
// Timer, mode and latch updates for a beat are combinational, ahead of the output buffer.
// A two-entry output buffer (result register plus skid) keeps in_ch.ready high while one
// result waits; in_ch.ready drops only when both entries are full.
// rst_n is synchronous, active low; it clears mode, timers and buffer, loads register defaults.
module led_clock_mode_and_display_scan_core (
  input  logic                            clk,
  input  logic                            rst_n,
  ledclk_tick_if.sink                     in_ch,
  ledclk_disp_if.source                   out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ledclk_pkg::PADDR_W-1:0]  paddr,
  input  logic [ledclk_pkg::PDATA_W-1:0]  pwdata,
  output logic [ledclk_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready
);

  typedef enum logic [1:0] {
    MODE_WATCH = 2'd0,
    MODE_TEMP  = 2'd1,
    MODE_SETUP = 2'd2
  } mode_t;

  localparam int CW = ledclk_pkg::COUNT_W;

  ledclk_pkg::cfg_t      cfg;
  ledclk_pkg::scan_req_t scan_req;
  ledclk_pkg::result_t   res, out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  mode_t mode_r, mode_nxt;
  logic [1:0] scan_r;
  logic [4:0] lat_hour_r, lat_hour_nxt, shown_hour_r, shown_hour_nxt;
  logic [5:0] lat_min_r, lat_min_nxt, shown_min_r, shown_min_nxt;
  logic [6:0] lat_temp_r, lat_temp_nxt;
  logic editing_hours_r, editing_hours_nxt, edited_r, edited_nxt;
  logic phase_r, phase_nxt, colon_r, colon_nxt, show_run_r, show_run_nxt;
  logic [CW-1:0] blink_cnt_r, blink_cnt_nxt, poll_cnt_r, poll_cnt_nxt;
  logic [CW-1:0] every_cnt_r, every_cnt_nxt, show_cnt_r, show_cnt_nxt;
  logic [CW-1:0] blink_p, poll_p, every_p, show_p, show_inc;
  logic blink_fire, poll_fire, every_fire, show_fire;
  logic signed [9:0] temp_corr;
  logic [5:0] hour_inc;
  logic [6:0] min_inc;
  logic wr_strobe;
  logic [4:0] wr_hour;
  logic [5:0] wr_min;
  logic acc, out_pop;

  ledclk_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = !skid_valid_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_pop     = out_valid_r && out_ch.ready;

  // period zero fires every tick
  assign blink_p = (cfg.blink_ticks == '0) ? CW'(1) : cfg.blink_ticks;
  assign poll_p  = (cfg.poll_ticks == '0) ? CW'(1) : cfg.poll_ticks;
  assign every_p = (cfg.temp_every_ticks == '0) ? CW'(1) : cfg.temp_every_ticks;
  assign show_p  = (cfg.temp_show_ticks == '0) ? CW'(1) : cfg.temp_show_ticks;

  always_comb begin
    blink_cnt_nxt = blink_cnt_r + CW'(1);
    blink_fire    = blink_cnt_nxt >= blink_p;
    if (blink_fire) blink_cnt_nxt = '0;
    poll_cnt_nxt  = poll_cnt_r + CW'(1);
    poll_fire     = poll_cnt_nxt >= poll_p;
    if (poll_fire) poll_cnt_nxt = '0;
    every_cnt_nxt = every_cnt_r + CW'(1);
    every_fire    = every_cnt_nxt >= every_p;
    if (every_fire) every_cnt_nxt = '0;
    show_inc      = show_cnt_r + CW'(1);
    show_cnt_nxt  = show_cnt_r;
    show_fire     = 1'b0;
    if (show_run_r) begin
      show_fire    = show_inc >= show_p;
      show_cnt_nxt = show_fire ? '0 : show_inc;
    end

    temp_corr = $signed({{2{in_ch.rtc_temp[7]}}, in_ch.rtc_temp})
              - $signed({6'd0, cfg.temp_offset});
    lat_hour_nxt = lat_hour_r;
    lat_min_nxt  = lat_min_r;
    lat_temp_nxt = lat_temp_r;
    if (poll_fire) begin
      lat_hour_nxt = in_ch.rtc_hour;
      lat_min_nxt  = in_ch.rtc_minute;
      if (temp_corr < 0) lat_temp_nxt = '0;
      else if (temp_corr > 10'sd99) lat_temp_nxt = ledclk_pkg::TEMP_MAX;
      else lat_temp_nxt = temp_corr[6:0];
    end

    mode_nxt          = mode_r;
    shown_hour_nxt    = shown_hour_r;
    shown_min_nxt     = shown_min_r;
    show_run_nxt      = show_run_r;
    editing_hours_nxt = editing_hours_r;
    edited_nxt        = edited_r;
    phase_nxt         = phase_r;
    colon_nxt         = colon_r;
    wr_strobe         = 1'b0;
    wr_hour           = '0;
    wr_min            = '0;

    if (in_ch.main_hold) begin
      mode_nxt       = MODE_SETUP;
      shown_hour_nxt = lat_hour_nxt;
      shown_min_nxt  = lat_min_nxt;
      show_run_nxt   = 1'b0;
      show_cnt_nxt   = '0;
    end

    if (every_fire && mode_nxt != MODE_TEMP && mode_nxt != MODE_SETUP) begin
      mode_nxt     = MODE_TEMP;
      show_run_nxt = 1'b1;
      show_cnt_nxt = '0;
      show_fire    = 1'b0;
    end

    hour_inc = {1'b0, shown_hour_nxt} + 6'd1;
    min_inc  = {1'b0, shown_min_nxt} + 7'd1;

    case (mode_nxt)
      MODE_SETUP: begin
        if (blink_fire) phase_nxt = !phase_r;
        if (in_ch.add_press) begin
          edited_nxt = 1'b1;
          if (editing_hours_r)
            shown_hour_nxt = (hour_inc > {1'b0, ledclk_pkg::HOUR_MAX}) ? '0 : hour_inc[4:0];
          else
            shown_min_nxt = (min_inc > {1'b0, ledclk_pkg::MIN_MAX}) ? '0 : min_inc[5:0];
        end
        if (in_ch.main_click) begin
          edited_nxt = 1'b0;
          if (editing_hours_r) begin
            editing_hours_nxt = 1'b0;
          end else begin
            editing_hours_nxt = 1'b1;
            wr_strobe = 1'b1;
            wr_hour   = shown_hour_nxt;
            wr_min    = shown_min_nxt;
            mode_nxt  = MODE_WATCH;
          end
        end
        colon_nxt = 1'b0;
      end
      MODE_TEMP: begin
        colon_nxt = 1'b0;
        if (show_fire) begin
          mode_nxt     = MODE_WATCH;
          show_run_nxt = 1'b0;
        end
      end
      default: begin
        shown_hour_nxt = lat_hour_nxt;
        shown_min_nxt  = lat_min_nxt;
        if (blink_fire) colon_nxt = !colon_r;
      end
    endcase

    scan_req.rank      = scan_r;
    scan_req.temp_mode = (mode_nxt == MODE_TEMP);
    scan_req.blank_hi  = (mode_nxt == MODE_SETUP) && !edited_nxt && !phase_nxt
                         && editing_hours_nxt;
    scan_req.blank_lo  = (mode_nxt == MODE_SETUP) && !edited_nxt && !phase_nxt
                         && !editing_hours_nxt;
    scan_req.hour      = shown_hour_nxt;
    scan_req.minute    = shown_min_nxt;
    scan_req.temp      = lat_temp_nxt;
  end

  ledclk_scan u_scan (
    .req          (scan_req),
    .digit_enable (res.digit_enable),
    .segments     (res.segments)
  );

  assign res.colon      = colon_nxt;
  assign res.rtc_write  = wr_strobe;
  assign res.set_hour   = wr_hour;
  assign res.set_minute = wr_min;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_pop) begin
      // skid holds the older beat, so it goes out first
      out_valid_nxt  = skid_valid_r || acc;
      out_nxt        = skid_valid_r ? skid_r : res;
      skid_valid_nxt = 1'b0;
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_WATCH;
      scan_r          <= '0;
      lat_hour_r      <= '0;
      lat_min_r       <= '0;
      lat_temp_r      <= '0;
      shown_hour_r    <= '0;
      shown_min_r     <= '0;
      editing_hours_r <= 1'b1;
      edited_r        <= 1'b0;
      phase_r         <= 1'b0;
      colon_r         <= 1'b0;
      show_run_r      <= 1'b0;
      blink_cnt_r     <= '0;
      poll_cnt_r      <= '0;
      every_cnt_r     <= '0;
      show_cnt_r      <= '0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
      out_r           <= '0;
      skid_r          <= '0;
    end else begin
      if (acc) begin
        mode_r          <= mode_nxt;
        scan_r          <= scan_r + 2'd1;
        lat_hour_r      <= lat_hour_nxt;
        lat_min_r       <= lat_min_nxt;
        lat_temp_r      <= lat_temp_nxt;
        shown_hour_r    <= shown_hour_nxt;
        shown_min_r     <= shown_min_nxt;
        editing_hours_r <= editing_hours_nxt;
        edited_r        <= edited_nxt;
        phase_r         <= phase_nxt;
        colon_r         <= colon_nxt;
        show_run_r      <= show_run_nxt;
        blink_cnt_r     <= blink_cnt_nxt;
        poll_cnt_r      <= poll_cnt_nxt;
        every_cnt_r     <= every_cnt_nxt;
        show_cnt_r      <= show_cnt_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      out_r        <= out_nxt;
      skid_r       <= skid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digit_enable = out_r.digit_enable;
  assign out_ch.segments     = out_r.segments;
  assign out_ch.colon        = out_r.colon;
  assign out_ch.rtc_write    = out_r.rtc_write;
  assign out_ch.set_hour     = out_r.set_hour;
  assign out_ch.set_minute   = out_r.set_minute;

  a_temp_run_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_TEMP) == show_run_r)
    else $error("temperature timer running out of step with mode");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while result register empty");

  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> scan_r == $past(scan_r) + 2'd1)
    else $error("scan digit did not advance on accepted beat");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    lat_temp_r <= ledclk_pkg::TEMP_MAX)
    else $error("latched temperature above 99");

  a_write_only_setup: assert property (@(posedge clk) disable iff (!rst_n)
    acc && wr_strobe |-> mode_r == MODE_SETUP || in_ch.main_hold)
    else $error("RTC write outside setup mode");

endmodule

// File: hdl/ledclk_regs.sv
`timescale 1ns / 1ps
module ledclk_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ledclk_pkg::PADDR_W-1:0]  paddr,
  input  logic [ledclk_pkg::PDATA_W-1:0]  pwdata,
  output logic [ledclk_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  output ledclk_pkg::cfg_t                cfg
);

  ledclk_pkg::cfg_t cfg_r;
  logic [ledclk_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[ledclk_pkg::PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_ticks      <= ledclk_pkg::BLINK_TICKS_RST;
      cfg_r.poll_ticks       <= ledclk_pkg::POLL_TICKS_RST;
      cfg_r.temp_every_ticks <= ledclk_pkg::TEMP_EVERY_RST;
      cfg_r.temp_show_ticks  <= ledclk_pkg::TEMP_SHOW_RST;
      cfg_r.temp_offset      <= ledclk_pkg::TEMP_OFFSET_RST;
    end else if (wr_en) begin
      case (idx)
        ledclk_pkg::REG_BLINK_TICKS: cfg_r.blink_ticks <= pwdata[ledclk_pkg::COUNT_W-1:0];
        ledclk_pkg::REG_POLL_TICKS:  cfg_r.poll_ticks  <= pwdata[ledclk_pkg::COUNT_W-1:0];
        ledclk_pkg::REG_TEMP_EVERY:  cfg_r.temp_every_ticks <= pwdata[ledclk_pkg::COUNT_W-1:0];
        ledclk_pkg::REG_TEMP_SHOW:   cfg_r.temp_show_ticks  <= pwdata[ledclk_pkg::COUNT_W-1:0];
        ledclk_pkg::REG_TEMP_OFFSET: cfg_r.temp_offset <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ledclk_pkg::REG_BLINK_TICKS:
        prdata = ledclk_pkg::PDATA_W'(cfg_r.blink_ticks);
      ledclk_pkg::REG_POLL_TICKS:
        prdata = ledclk_pkg::PDATA_W'(cfg_r.poll_ticks);
      ledclk_pkg::REG_TEMP_EVERY:
        prdata = ledclk_pkg::PDATA_W'(cfg_r.temp_every_ticks);
      ledclk_pkg::REG_TEMP_SHOW:
        prdata = ledclk_pkg::PDATA_W'(cfg_r.temp_show_ticks);
      ledclk_pkg::REG_TEMP_OFFSET:
        prdata = ledclk_pkg::PDATA_W'(cfg_r.temp_offset);
      default: prdata = '0;
    endcase
  end

endmodule

// File: hdl/ledclk_scan.sv
`timescale 1ns / 1ps
module ledclk_scan (
  input  ledclk_pkg::scan_req_t req,
  output logic [3:0]            digit_enable,
  output logic [6:0]            segments
);

  logic [6:0] pair_val;
  logic [7:0] split;
  logic [3:0] dig;

  always_comb begin
    if (req.temp_mode) pair_val = req.temp;
    else if (!req.rank[1]) pair_val = {2'b00, req.hour};
    else pair_val = {1'b0, req.minute};
    split = ledclk_pkg::dec_split(pair_val);
    // left digit of a pair is tens, right is ones
    dig = req.rank[0] ? split[3:0] : split[7:4];

    digit_enable = 4'b0001 << req.rank;
    if (req.temp_mode) begin
      case (req.rank)
        2'd0: segments = ledclk_pkg::SEG_BLANK;
        2'd1: segments = ledclk_pkg::SEG_STAR;
        default: segments = ledclk_pkg::digit_seg(dig);
      endcase
    end else begin
      segments = ledclk_pkg::digit_seg(dig);
      if ((!req.rank[1] && req.blank_hi) || (req.rank[1] && req.blank_lo))
        digit_enable = 4'b0000;
    end
  end

endmodule
